### hw/rtl/dra_pkg.sv
// Shared types and constants for the DNS reply answer extractor.
`default_nettype none
package dra_pkg;

    localparam int HDR_LEN   = 12;
    localparam int FIXED_LEN = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0]  LABEL_MAX   = 8'd63;
    localparam logic [15:0] QR_MASK     = 16'h8000;
    localparam logic [7:0]  OPCODE_MASK = 8'h78;
    localparam logic [15:0] RCODE_MASK  = 16'h000f;

    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_TYPE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CLASS = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_QUESTION,
        PH_ANAME,
        PH_AFIXED,
        PH_RDATA,
        PH_DONE,
        PH_FAILED
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_ID_MISMATCH,
        ST_MALFORMED,
        ST_RCODE,
        ST_NO_ANSWERS
    } status_t;

    typedef struct packed {
        logic [15:0] expected_id;
        logic [15:0] expected_type;
        logic [15:0] expected_class;
    } cfg_t;

    typedef struct packed {
        logic        is_status;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic [3:0]  server_code;
        logic [15:0] data_length;
        logic        last;
    } result_t;

    // up to two results per item: an rdata byte, then the packet status
    typedef struct packed {
        logic    data_valid;
        result_t data;
        logic    status_valid;
        result_t stat;
    } push_t;

endpackage
`default_nettype wire

### hw/rtl/dra_ifs.sv
// Channel interfaces: reply bytes in, results out, register writes.
`default_nettype none
interface dra_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_packet;
    modport source (output valid, rx_byte, end_of_packet, input ready);
    modport sink   (input valid, rx_byte, end_of_packet, output ready);
endinterface

interface dra_out_if;
    logic        valid;
    logic        ready;
    logic        is_status;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [3:0]  server_code;
    logic [15:0] data_length;
    logic        last;
    modport source (output valid, is_status, data_byte, status, server_code, data_length,
                    last, input ready);
    modport sink   (input valid, is_status, data_byte, status, server_code, data_length,
                    last, output ready);
endinterface

interface dra_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dra_pkg::CFG_IDX_W-1:0]  index;
    logic [15:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/dns_response_answer_extract_top.sv
// Top level of the DNS reply answer extractor.
// Takes one reply byte per cycle while the result queue has room and updates the parse
// state in that same cycle; the rdata bytes of the first answer matching the configured
// type and class, and one status result per packet, leave through a four-entry result
// queue. A byte is taken whenever the queue has two free entries, so with the result side
// ready the block sustains one byte per clock, the state update of each byte being done
// as it is taken. Results of a byte are registered in the queue. Registers are written
// through the configuration channel, which is always ready; write them between packets.
`default_nettype none
module dns_response_answer_extract_top #(
    parameter int MAX_PAYLOAD = 512
) (
    input  wire logic clk,
    input  wire logic rst_n,
    dra_in_if.sink    in_ch,
    dra_out_if.source out_ch,
    dra_cfg_if.sink   cfg
);

    dra_pkg::cfg_t    cfg_val;
    dra_pkg::push_t   push;
    dra_pkg::result_t head;
    logic             head_valid;
    logic             has_room;
    logic             in_accept;

    assign in_ch.ready = has_room;
    assign in_accept   = in_ch.valid & has_room;

    dra_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    dra_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .rx_byte       (in_ch.rx_byte),
        .end_of_packet (in_ch.end_of_packet),
        .cfg           (cfg_val),
        .push          (push)
    );

    dra_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (out_ch.ready),
        .head       (head),
        .head_valid (head_valid),
        .has_room   (has_room)
    );

    assign out_ch.valid       = head_valid;
    assign out_ch.is_status   = head.is_status;
    assign out_ch.data_byte   = head.data_byte;
    assign out_ch.status      = head.status;
    assign out_ch.server_code = head.server_code;
    assign out_ch.data_length = head.data_length;
    assign out_ch.last        = head.last;

endmodule
`default_nettype wire

### hw/rtl/dra_cfg_regs.sv
// Configuration registers: expected ID, type and class.
`default_nettype none
module dra_cfg_regs (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dra_cfg_if.sink       cfg,
    output dra_pkg::cfg_t cfg_out
);

    dra_pkg::cfg_t cfg_reg;
    dra_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                dra_pkg::REG_EXPECTED_ID:    cfg_next.expected_id    = cfg.data;
                dra_pkg::REG_EXPECTED_TYPE:  cfg_next.expected_type  = cfg.data;
                dra_pkg::REG_EXPECTED_CLASS: cfg_next.expected_class = cfg.data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_id    <= 16'd0;
            cfg_reg.expected_type  <= 16'd1;
            cfg_reg.expected_class <= 16'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/dra_parser.sv
// Per-byte parse state and the combinational update for one reply byte.
`default_nettype none
module dra_parser #(
    parameter int MAX_PAYLOAD = 512
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          end_of_packet,
    input  wire dra_pkg::cfg_t cfg,
    output dra_pkg::push_t     push
);

    localparam int LIMIT = dra_pkg::HDR_LEN + MAX_PAYLOAD;
    localparam int POS_W = $clog2(LIMIT + 1);
    // decision point can lie a whole rdlength beyond the last byte taken
    localparam int NDP_W = $clog2(LIMIT + 65536 + 16);

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LIMIT);
    localparam logic [POS_W-1:0] POS_HDR   = POS_W'(dra_pkg::HDR_LEN);
    localparam logic [POS_W-1:0] POS_HLAST = POS_W'(dra_pkg::HDR_LEN - 1);
    localparam logic [NDP_W-1:0] NDP_HDR   = NDP_W'(dra_pkg::HDR_LEN);
    localparam logic [NDP_W-1:0] NDP_FIXED = NDP_W'(dra_pkg::FIXED_LEN);

    logic [POS_W-1:0]     pos_reg,   pos_next;
    logic [15:0]          id_reg,    id_next;
    logic [15:0]          flags_reg, flags_next;
    logic [15:0]          qtot_reg,  qtot_next;
    logic [15:0]          atot_reg,  atot_next;
    dra_pkg::phase_t      phase_reg, phase_next;
    logic [NDP_W-1:0]     ndp_reg,   ndp_next;
    logic [15:0]          qskip_reg, qskip_next;
    logic [15:0]          aseen_reg, aseen_next;
    logic [47:0]          rf_reg,    rf_next;
    logic [15:0]          rem_reg,   rem_next;

    logic [NDP_W-1:0]     pos_ext;
    logic [NDP_W-1:0]     fixed_off;
    logic                 at_decision;
    logic                 name_end;
    dra_pkg::status_t     st;

    function automatic dra_pkg::status_t hdr_err(
        input logic        hdr_done,
        input logic [15:0] id,
        input logic [15:0] flags,
        input logic [15:0] atot,
        input logic [15:0] exp_id
    );
        dra_pkg::status_t r;
        if (!hdr_done)
            r = dra_pkg::ST_MALFORMED;
        else if (id != exp_id)
            r = dra_pkg::ST_ID_MISMATCH;
        else if ((flags & dra_pkg::QR_MASK) == 16'd0
                 || (flags[15:8] & dra_pkg::OPCODE_MASK) != 8'd0)
            r = dra_pkg::ST_MALFORMED;
        else if ((flags & dra_pkg::RCODE_MASK) != 16'd0)
            r = dra_pkg::ST_RCODE;
        else if (atot == 16'd0)
            r = dra_pkg::ST_NO_ANSWERS;
        else
            r = dra_pkg::ST_OK;
        return r;
    endfunction

    assign pos_ext     = NDP_W'(pos_reg);
    assign fixed_off   = pos_ext - ndp_reg;
    assign at_decision = (pos_ext == ndp_reg);
    // zero ends the name; anything above a label length is a pointer
    assign name_end    = (rx_byte > dra_pkg::LABEL_MAX) || (rx_byte == 8'd0);

    always_comb
    begin
        pos_next   = pos_reg;
        id_next    = id_reg;
        flags_next = flags_reg;
        qtot_next  = qtot_reg;
        atot_next  = atot_reg;
        phase_next = phase_reg;
        ndp_next   = ndp_reg;
        qskip_next = qskip_reg;
        aseen_next = aseen_reg;
        rf_next    = rf_reg;
        rem_next   = rem_reg;
        push       = '0;
        st         = dra_pkg::ST_OK;

        if (accept && pos_reg < POS_LIMIT)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg < POS_HDR)
            begin
                if (pos_reg < POS_W'(2))
                    id_next = {id_reg[7:0], rx_byte};
                else if (pos_reg < POS_W'(4))
                    flags_next = {flags_reg[7:0], rx_byte};
                else if (pos_reg < POS_W'(6))
                    qtot_next = {qtot_reg[7:0], rx_byte};
                else if (pos_reg < POS_W'(8))
                    atot_next = {atot_reg[7:0], rx_byte};
                if (pos_reg == POS_HLAST)
                begin
                    ndp_next = NDP_HDR;
                    if (hdr_err(1'b1, id_next, flags_next, atot_next, cfg.expected_id)
                        != dra_pkg::ST_OK)
                        phase_next = dra_pkg::PH_FAILED;
                    else if (qtot_next == 16'd0)
                        phase_next = dra_pkg::PH_ANAME;
                    else
                        phase_next = dra_pkg::PH_QUESTION;
                end
            end
            else
            begin
                unique case (phase_reg)
                    dra_pkg::PH_QUESTION:
                    begin
                        if (at_decision)
                        begin
                            if (name_end)
                            begin
                                // name end plus type and class
                                ndp_next   = ndp_reg + ((rx_byte > dra_pkg::LABEL_MAX)
                                             ? NDP_W'(6) : NDP_W'(5));
                                qskip_next = qskip_reg + 16'd1;
                                if (qskip_next >= qtot_reg)
                                    phase_next = dra_pkg::PH_ANAME;
                            end
                            else
                            begin
                                ndp_next = ndp_reg + NDP_W'(rx_byte) + NDP_W'(1);
                            end
                        end
                    end
                    dra_pkg::PH_ANAME:
                    begin
                        if (at_decision)
                        begin
                            if (name_end)
                            begin
                                ndp_next   = ndp_reg + ((rx_byte > dra_pkg::LABEL_MAX)
                                             ? NDP_W'(2) : NDP_W'(1));
                                rf_next    = '0;
                                phase_next = dra_pkg::PH_AFIXED;
                            end
                            else
                            begin
                                ndp_next = ndp_reg + NDP_W'(rx_byte) + NDP_W'(1);
                            end
                        end
                    end
                    dra_pkg::PH_AFIXED:
                    begin
                        if (pos_ext >= ndp_reg)
                        begin
                            // keep type, class and rdlength; drop the TTL bytes
                            if (fixed_off < NDP_W'(4) || fixed_off == NDP_W'(8)
                                || fixed_off == NDP_W'(9))
                                rf_next = {rf_reg[39:0], rx_byte};
                            if (fixed_off == NDP_W'(9))
                            begin
                                if (rf_next[47:32] == cfg.expected_type
                                    && rf_next[31:16] == cfg.expected_class)
                                begin
                                    rem_next   = rf_next[15:0];
                                    phase_next = (rf_next[15:0] == 16'd0)
                                                 ? dra_pkg::PH_DONE : dra_pkg::PH_RDATA;
                                end
                                else
                                begin
                                    aseen_next = aseen_reg + 16'd1;
                                    if (aseen_next >= atot_reg)
                                    begin
                                        phase_next = dra_pkg::PH_FAILED;
                                    end
                                    else
                                    begin
                                        ndp_next   = ndp_reg + NDP_FIXED
                                                     + NDP_W'(rf_next[15:0]);
                                        phase_next = dra_pkg::PH_ANAME;
                                    end
                                end
                            end
                        end
                    end
                    dra_pkg::PH_RDATA:
                    begin
                        push.data_valid       = 1'b1;
                        push.data.is_status   = 1'b0;
                        push.data.data_byte   = rx_byte;
                        push.data.status      = dra_pkg::ST_OK;
                        push.data.server_code = flags_reg[3:0];
                        push.data.data_length = rf_reg[15:0];
                        push.data.last        = 1'b0;
                        rem_next = rem_reg - 16'd1;
                        if (rem_next == 16'd0)
                            phase_next = dra_pkg::PH_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        if (accept && end_of_packet)
        begin
            if (phase_next == dra_pkg::PH_DONE)
                st = dra_pkg::ST_OK;
            else
            begin
                st = hdr_err(pos_next >= POS_HDR, id_next, flags_next, atot_next,
                             cfg.expected_id);
                if (st == dra_pkg::ST_OK)
                    st = dra_pkg::ST_MALFORMED;
            end
            push.status_valid       = 1'b1;
            push.stat.is_status     = 1'b1;
            push.stat.data_byte     = 8'd0;
            push.stat.status        = st;
            push.stat.server_code   = flags_next[3:0];
            push.stat.data_length   = (st == dra_pkg::ST_OK) ? rf_next[15:0] : 16'd0;
            push.stat.last          = 1'b1;

            pos_next   = '0;
            id_next    = '0;
            flags_next = '0;
            qtot_next  = '0;
            atot_next  = '0;
            phase_next = dra_pkg::PH_HEADER;
            ndp_next   = '0;
            qskip_next = '0;
            aseen_next = '0;
            rf_next    = '0;
            rem_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            id_reg    <= '0;
            flags_reg <= '0;
            qtot_reg  <= '0;
            atot_reg  <= '0;
            phase_reg <= dra_pkg::PH_HEADER;
            ndp_reg   <= '0;
            qskip_reg <= '0;
            aseen_reg <= '0;
            rf_reg    <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            id_reg    <= id_next;
            flags_reg <= flags_next;
            qtot_reg  <= qtot_next;
            atot_reg  <= atot_next;
            phase_reg <= phase_next;
            ndp_reg   <= ndp_next;
            qskip_reg <= qskip_next;
            aseen_reg <= aseen_next;
            rf_reg    <= rf_next;
            rem_reg   <= rem_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/dra_out_fifo.sv
// Four-entry result queue taking up to two results per cycle.
`default_nettype none
module dra_out_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dra_pkg::push_t push,
    input  wire logic           pop,
    output dra_pkg::result_t    head,
    output logic                head_valid,
    output logic                has_room
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dra_pkg::result_t entry_reg  [DEPTH];
    dra_pkg::result_t entry_next [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             w0_valid, w1_valid, do_pop;
    dra_pkg::result_t w0, w1;
    logic [PTR_W-1:0] wptr_plus1;

    assign w0_valid   = push.data_valid | push.status_valid;
    assign w1_valid   = push.data_valid & push.status_valid;
    assign w0         = push.data_valid ? push.data : push.stat;
    assign w1         = push.stat;
    assign wptr_plus1 = wptr_reg + 1'b1;
    assign do_pop     = pop && (count_reg != '0);

    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rptr_reg];
    // room for the worst case of two results from the next item
    assign has_room   = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (w0_valid && wptr_reg == PTR_W'(i))
                entry_next[i] = w0;
            else if (w1_valid && wptr_plus1 == PTR_W'(i))
                entry_next[i] = w1;
        end
        wptr_next  = wptr_reg + PTR_W'(w0_valid) + PTR_W'(w1_valid);
        rptr_next  = rptr_reg + PTR_W'(do_pop);
        count_next = count_reg + CNT_W'(w0_valid) + CNT_W'(w1_valid) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
            entry_reg[i] <= entry_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/dra_checker.sv
// Port-level assertions for the answer extractor, bound to the top level.
`default_nettype none
module dra_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        is_status,
    input wire logic [7:0]  data_byte,
    input wire logic [2:0]  status,
    input wire logic [15:0] data_length,
    input wire logic        last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_status) && $stable(data_byte)
            && $stable(status) && $stable(data_length) && $stable(last))
        else $error("result changed while stalled");

    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == is_status))
        else $error("last does not mark the status item");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_status |-> (status == 3'd0) && (data_length != 16'd0))
        else $error("data item with status or empty record length");

    a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_status && (status != 3'd0) |-> (data_length == 16'd0)
            && (data_byte == 8'd0))
        else $error("failed status carries a length or data");

endmodule

bind dns_response_answer_extract_top dra_checker u_dra_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .is_status   (out_ch.is_status),
    .data_byte   (out_ch.data_byte),
    .status      (out_ch.status),
    .data_length (out_ch.data_length),
    .last        (out_ch.last)
);
`default_nettype wire

### dv/dra_reply_tracker.sv
// Watches the reply, result and register channels, predicts every result item and compares.
`timescale 1ns / 100ps
module dra_reply_tracker #(
    parameter int MAX_PAYLOAD = 512
) (
    input  logic clk,
    input  logic rst_n,
    dra_in_if    in_ch,
    dra_out_if   out_ch,
    dra_cfg_if   cfg,
    output int   fail_count,
    output int   pending,
    output int   checked,
    output int   ok_replies
);

    dra_pkg::cfg_t    regs;
    int unsigned      pos_count;
    logic [15:0]      hdr_id;
    logic [15:0]      hdr_flags;
    logic [15:0]      qd_total;
    logic [15:0]      an_total;
    dra_pkg::phase_t  phase;
    int unsigned      next_pos;
    logic [15:0]      q_done;
    logic [15:0]      a_done;
    logic [47:0]      rec;
    logic [15:0]      rd_left;

    dra_pkg::result_t due_results[$];
    dra_pkg::result_t want;
    int               errs = 0;
    int               n_checked = 0;
    int               n_ok = 0;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        ok_replies = 0;
    end

    task automatic clear_reply();
        pos_count = 0;
        hdr_id    = '0;
        hdr_flags = '0;
        qd_total  = '0;
        an_total  = '0;
        phase     = dra_pkg::PH_HEADER;
        next_pos  = 0;
        q_done    = '0;
        a_done    = '0;
        rec       = '0;
        rd_left   = '0;
    endtask

    function automatic dra_pkg::status_t header_verdict();
        if (pos_count < dra_pkg::HDR_LEN)
            return dra_pkg::ST_MALFORMED;
        if (hdr_id != regs.expected_id)
            return dra_pkg::ST_ID_MISMATCH;
        if ((hdr_flags & dra_pkg::QR_MASK) == '0
            || (hdr_flags[15:8] & dra_pkg::OPCODE_MASK) != '0)
            return dra_pkg::ST_MALFORMED;
        if ((hdr_flags & dra_pkg::RCODE_MASK) != '0)
            return dra_pkg::ST_RCODE;
        if (an_total == '0)
            return dra_pkg::ST_NO_ANSWERS;
        return dra_pkg::ST_OK;
    endfunction

    task automatic take_reply_byte(logic [7:0] b, int unsigned p);
        int unsigned      k;
        dra_pkg::result_t r;
        if (p < dra_pkg::HDR_LEN)
        begin
            if (p < 2)
                hdr_id = {hdr_id[7:0], b};
            else if (p < 4)
                hdr_flags = {hdr_flags[7:0], b};
            else if (p < 6)
                qd_total = {qd_total[7:0], b};
            else if (p < 8)
                an_total = {an_total[7:0], b};
            if (p == dra_pkg::HDR_LEN - 1)
            begin
                next_pos = dra_pkg::HDR_LEN;
                if (header_verdict() != dra_pkg::ST_OK)
                    phase = dra_pkg::PH_FAILED;
                else
                    phase = (qd_total == '0) ? dra_pkg::PH_ANAME : dra_pkg::PH_QUESTION;
            end
            return;
        end
        case (phase)
            dra_pkg::PH_QUESTION:
                if (p == next_pos)
                begin
                    // pointer or root ends the name; type and class follow
                    if (b > dra_pkg::LABEL_MAX || b == '0)
                    begin
                        next_pos += (b > dra_pkg::LABEL_MAX) ? 6 : 5;
                        q_done++;
                        if (q_done >= qd_total)
                            phase = dra_pkg::PH_ANAME;
                    end
                    else
                        next_pos += b + 1;
                end
            dra_pkg::PH_ANAME:
                if (p == next_pos)
                begin
                    if (b > dra_pkg::LABEL_MAX || b == '0)
                    begin
                        next_pos += (b > dra_pkg::LABEL_MAX) ? 2 : 1;
                        rec = '0;
                        phase = dra_pkg::PH_AFIXED;
                    end
                    else
                        next_pos += b + 1;
                end
            dra_pkg::PH_AFIXED:
                if (p >= next_pos)
                begin
                    k = p - next_pos;
                    // type, class and rdlength; the TTL is skipped
                    if (k < 4 || k == 8 || k == 9)
                        rec = {rec[39:0], b};
                    if (k == 9)
                    begin
                        if (rec[47:32] == regs.expected_type
                            && rec[31:16] == regs.expected_class)
                        begin
                            rd_left = rec[15:0];
                            phase = (rd_left == '0) ? dra_pkg::PH_DONE : dra_pkg::PH_RDATA;
                        end
                        else
                        begin
                            a_done++;
                            if (a_done >= an_total)
                                phase = dra_pkg::PH_FAILED;
                            else
                            begin
                                next_pos += dra_pkg::FIXED_LEN + rec[15:0];
                                phase = dra_pkg::PH_ANAME;
                            end
                        end
                    end
                end
            dra_pkg::PH_RDATA:
            begin
                r = '0;
                r.data_byte   = b;
                r.server_code = hdr_flags[3:0];
                r.data_length = rec[15:0];
                due_results.push_back(r);
                rd_left--;
                if (rd_left == '0)
                    phase = dra_pkg::PH_DONE;
            end
            default: ;
        endcase
    endtask

    task automatic take_item(logic [7:0] b, logic eop);
        dra_pkg::status_t st;
        dra_pkg::result_t r;
        int unsigned      p;
        // bytes past the payload limit are dropped, but the end mark still counts
        if (pos_count < dra_pkg::HDR_LEN + MAX_PAYLOAD)
        begin
            p = pos_count;
            pos_count++;
            take_reply_byte(b, p);
        end
        if (eop)
        begin
            if (phase == dra_pkg::PH_DONE)
                st = dra_pkg::ST_OK;
            else
            begin
                st = header_verdict();
                if (st == dra_pkg::ST_OK)
                    st = dra_pkg::ST_MALFORMED;
            end
            r = '0;
            r.is_status   = 1'b1;
            r.status      = st;
            r.server_code = hdr_flags[3:0];
            r.data_length = (st == dra_pkg::ST_OK) ? rec[15:0] : 16'h0000;
            r.last        = 1'b1;
            due_results.push_back(r);
            if (st == dra_pkg::ST_OK)
                n_ok++;
            clear_reply();
        end
    endtask

    task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.expected_id    = 16'h0000;
            regs.expected_type  = 16'h0001;
            regs.expected_class = 16'h0001;
            clear_reply();
            due_results.delete();
        end
        else
        begin
            // results first, so an item accepted at this edge cannot match its own output
            if (out_ch.valid && out_ch.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result item with none expected: is_status %0b data 0x%0h status %0d",
                           out_ch.is_status, out_ch.data_byte, out_ch.status);
                    errs++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("is_status", want.is_status, out_ch.is_status);
                    check_field("data_byte", want.data_byte, out_ch.data_byte);
                    check_field("status", want.status, out_ch.status);
                    check_field("server_code", want.server_code, out_ch.server_code);
                    check_field("data_length", want.data_length, out_ch.data_length);
                    check_field("last", want.last, out_ch.last);
                    n_checked++;
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    dra_pkg::REG_EXPECTED_ID:    regs.expected_id    = cfg.data;
                    dra_pkg::REG_EXPECTED_TYPE:  regs.expected_type  = cfg.data;
                    dra_pkg::REG_EXPECTED_CLASS: regs.expected_class = cfg.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                take_item(in_ch.rx_byte, in_ch.end_of_packet);
        end
        fail_count <= errs;
        pending    <= due_results.size();
        checked    <= n_checked;
        ok_replies <= n_ok;
    end

endmodule

### dv/tb_dns_response_answer_extract_top.sv
// Testbench top: reset, reply packet stimulus, register phases, flow control and verdict.
`timescale 1ns / 100ps
module tb_dns_response_answer_extract_top;

    localparam int PAYLOAD_LIMIT = 512;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASES        = 8;
    localparam int PHASE_BYTES   = 160;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            cycle_count = 0;
    int            n_replies = 0;
    int            n_bytes = 0;
    int            fail_count;
    int            pending;
    int            checked;
    int            ok_replies;
    dra_pkg::cfg_t cur_cfg;
    logic [7:0]    reply[$];

    dra_in_if  in_ch();
    dra_out_if out_ch();
    dra_cfg_if cfg_ch();

    dns_response_answer_extract_top #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    dra_reply_tracker #(
        .MAX_PAYLOAD(PAYLOAD_LIMIT)
    ) u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .ok_replies (ok_replies)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_name();
        int labels;
        int len;
        labels = $urandom_range(0, 2);
        for (int i = 0; i < labels; i++)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 63)
                                               : $urandom_range(1, 6);
            reply.push_back(8'(len));
            repeat (len) reply.push_back(8'($urandom_range(0, 255)));
        end
        // compressed names end in a two-byte pointer, others in the root label
        if ($urandom_range(0, 2) == 0)
        begin
            reply.push_back(8'($urandom_range(64, 255)));
            reply.push_back(8'($urandom_range(0, 255)));
        end
        else
            reply.push_back(8'h00);
    endtask

    task automatic build_reply(bit big);
        int          kind;
        int          qd;
        int          an;
        int          hit;
        int          len;
        int          rdlen;
        bit          huge;
        logic [15:0] id;
        logic [15:0] rtype;
        logic [15:0] rclass;
        logic [7:0]  b2;
        logic [7:0]  b3;
        reply.delete();
        kind = big ? 99 : $urandom_range(0, 99);
        if (kind < 6)
        begin
            len = $urandom_range(1, 30);
            repeat (len) reply.push_back(8'($urandom_range(0, 255)));
            return;
        end
        id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : cur_cfg.expected_id;
        b2 = {1'b1, 4'b0000, 3'($urandom_range(0, 7))};
        if ($urandom_range(0, 19) == 0)
            b2[7] = 1'b0;
        if ($urandom_range(0, 19) == 0)
            b2[6:3] = 4'($urandom_range(1, 15));
        b3 = {4'($urandom_range(0, 15)), 4'h0};
        if ($urandom_range(0, 11) == 0)
            b3[3:0] = 4'($urandom_range(1, 15));
        qd = $urandom_range(0, 3);
        an = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 4);
        if (big)
        begin
            id = cur_cfg.expected_id;
            b2 = 8'h80;
            b3 = 8'h00;
            an = 1;
        end
        hit = (an == 0 || (!big && $urandom_range(0, 4) == 0)) ? -1 : $urandom_range(0, an - 1);
        reply.push_back(id[15:8]);
        reply.push_back(id[7:0]);
        reply.push_back(b2);
        reply.push_back(b3);
        reply.push_back(8'h00);
        reply.push_back(8'(qd));
        reply.push_back(8'h00);
        reply.push_back(8'(an));
        repeat (4) reply.push_back(8'($urandom_range(0, 255)));
        if (kind < 12)
        begin
            reply = reply[0:$urandom_range(0, 10)];
            return;
        end
        repeat (qd)
        begin
            add_name();
            repeat (4) reply.push_back(8'($urandom_range(0, 255)));
        end
        for (int a = 0; a < an; a++)
        begin
            add_name();
            if (a == hit)
            begin
                rtype  = cur_cfg.expected_type;
                rclass = cur_cfg.expected_class;
            end
            else
            begin
                // near misses: one of type and class right, or both random
                case ($urandom_range(0, 2))
                    0:
                    begin
                        rtype  = cur_cfg.expected_type;
                        rclass = cur_cfg.expected_class ^ (16'h0001 << $urandom_range(0, 15));
                    end
                    1:
                    begin
                        rtype  = cur_cfg.expected_type ^ (16'h0001 << $urandom_range(0, 15));
                        rclass = cur_cfg.expected_class;
                    end
                    default:
                    begin
                        rtype  = 16'($urandom);
                        rclass = 16'($urandom);
                    end
                endcase
            end
            huge = 1'b0;
            if (big && a == hit)
                rdlen = 520;
            else if ($urandom_range(0, 29) == 0)
            begin
                huge  = 1'b1;
                rdlen = $urandom_range(0, 1) ? 65535 : $urandom_range(200, 65534);
            end
            else
                rdlen = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40)
                                                    : $urandom_range(0, 10);
            reply.push_back(rtype[15:8]);
            reply.push_back(rtype[7:0]);
            reply.push_back(rclass[15:8]);
            reply.push_back(rclass[7:0]);
            repeat (4) reply.push_back(8'($urandom_range(0, 255)));
            reply.push_back(8'(rdlen >> 8));
            reply.push_back(8'(rdlen));
            if (huge)
            begin
                // record runs past the end of the packet
                repeat ($urandom_range(0, 6)) reply.push_back(8'($urandom_range(0, 255)));
                return;
            end
            repeat (rdlen) reply.push_back(8'($urandom_range(0, 255)));
            if (a == hit && $urandom_range(0, 1) == 0)
                break;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) reply.push_back(8'($urandom_range(0, 255)));
        if (!big && $urandom_range(0, 9) == 0 && reply.size() > 13)
            reply = reply[0:$urandom_range(11, reply.size() - 2)];
    endtask

    task automatic send_byte(logic [7:0] b, logic eop);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.rx_byte       <= b;
        in_ch.end_of_packet <= eop;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic send_reply();
        foreach (reply[i])
            send_byte(reply[i], i == reply.size() - 1);
        n_replies++;
        n_bytes += reply.size();
    endtask

    task automatic write_reg(logic [dra_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // drain every outstanding result, then let the block settle
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int phase_bytes;
        in_ch.valid         = 1'b0;
        in_ch.rx_byte       = 8'h00;
        in_ch.end_of_packet = 1'b0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = dra_pkg::REG_EXPECTED_ID;
        cfg_ch.data         = 16'h0000;
        cur_cfg.expected_id    = 16'h0000;
        cur_cfg.expected_type  = 16'h0001;
        cur_cfg.expected_class = 16'h0001;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // register reset values: a reply cut short in the header, then a minimal good one with one rdata byte
        reply = '{8'hff};
        send_reply();
        reply = '{8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                  8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h01, 8'h00, 8'h01,
                  8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h01, 8'hff};
        send_reply();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_quiet();
            case (ph)
                0:
                begin
                    cur_cfg.expected_id    = 16'h0000;
                    cur_cfg.expected_type  = 16'h0000;
                    cur_cfg.expected_class = 16'h0000;
                end
                1:
                begin
                    cur_cfg.expected_id    = 16'hffff;
                    cur_cfg.expected_type  = 16'hffff;
                    cur_cfg.expected_class = 16'hffff;
                end
                2:
                begin
                    cur_cfg.expected_id    = 16'($urandom);
                    cur_cfg.expected_type  = 16'h0001;
                    cur_cfg.expected_class = 16'h0001;
                end
                3:
                begin
                    cur_cfg.expected_id    = 16'($urandom);
                    cur_cfg.expected_type  = 16'h001c;
                    cur_cfg.expected_class = 16'h0001;
                end
                default:
                begin
                    cur_cfg.expected_id    = 16'($urandom);
                    cur_cfg.expected_type  = ($urandom_range(0, 3) == 0) ? 16'hffff
                                                                         : 16'($urandom);
                    cur_cfg.expected_class = 16'($urandom);
                end
            endcase
            write_reg(dra_pkg::REG_EXPECTED_ID, cur_cfg.expected_id);
            write_reg(dra_pkg::REG_EXPECTED_TYPE, cur_cfg.expected_type);
            write_reg(dra_pkg::REG_EXPECTED_CLASS, cur_cfg.expected_class);
            cfg_ch.valid <= 1'b0;
            case (ph % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 62; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                // one reply overruns the payload limit
                build_reply(ph == 2 && phase_bytes == 0);
                send_reply();
                phase_bytes += reply.size();
            end
        end

        wait_quiet();
        stall_pct = 0;
        repeat (6) @(posedge clk);
        $display("Covered %0d replies (%0d bytes) under %0d register settings",
                 n_replies, n_bytes, PHASES + 1);
        $display("and four flow-control mixes; compared %0d result items, %0d replies succeeded",
                 checked, ok_replies);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
